// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by the table rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// types and constants of the sorted pid status table
// ----------------------------------------------------------------------------
package sps_pkg;

   localparam int PID_W    = 22;
   localparam int STATUS_W = 64;
   localparam int CODE_W   = 2;
   localparam int COUNT_W  = 7;

   // status words, first character in the low byte
   localparam logic [STATUS_W-1:0] WORD_WAITING = 64'h0047_4E49_5449_4157;
   localparam logic [STATUS_W-1:0] WORD_DNE     = 64'h0000_0000_0045_4E44;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_LOOKUP = 2'd3
   } cmd_type;

   typedef enum logic [CODE_W-1:0] {
      RC_OK   = 2'd0,
      RC_MISS = 2'd1,
      RC_FULL = 2'd2
   } code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [PID_W-1:0]    pid;
      logic [STATUS_W-1:0] status;
   } entry_type;

endpackage

// ===== hdl/sps_entry_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_entry_ram
// single-port-write, single-port-read entry memory with registered read
// ----------------------------------------------------------------------------
module sps_entry_ram #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output sps_pkg::entry_type                rd_data,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  sps_pkg::entry_type                wr_data
);

   sps_pkg::entry_type mem [DEPTH];
   sps_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sorted_pid_status_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_pid_status_table
// bounded table of process ids in ascending order, each with a status word
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Entries live in one
// memory with a registered read; every command except an insert into a full
// table walks the stored entries from slot 0 upward, one read per cycle, and
// insert and delete shift entries in the same pass (insert ripples the
// displaced entry up by one, delete pulls the tail down by one). After the
// scan the command passes through a finish state, from which the result is
// registered onto rsp_valid; on an empty table the scan is skipped. An insert
// into a full table answers the next cycle. Results are shown for exactly one
// cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_pid_status_table #(
   parameter int CAPACITY = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_cmd,
   input  logic [sps_pkg::PID_W-1:0]        req_pid,
   input  logic [sps_pkg::STATUS_W-1:0]     req_status_in,
   output logic                             rsp_valid,
   output logic [sps_pkg::CODE_W-1:0]       rsp_result_code,
   output logic [sps_pkg::STATUS_W-1:0]     rsp_status_out,
   output logic [sps_pkg::COUNT_W-1:0]      rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   // control state
   sps_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic               pend_ff, pend_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   sps_pkg::cmd_type               cmd_ff, cmd_in;
   logic [sps_pkg::PID_W-1:0]      pid_ff, pid_in;
   logic [sps_pkg::STATUS_W-1:0]   stat_ff, stat_in;
   logic [AW-1:0]                  d_idx_ff, d_idx_in;
   sps_pkg::entry_type             hold_ff, hold_in;
   logic [sps_pkg::STATUS_W-1:0]   word_ff, word_in;
   sps_pkg::code_type              rsp_code_ff, rsp_code_in;
   logic [sps_pkg::STATUS_W-1:0]   rsp_word_ff, rsp_word_in;
   logic [sps_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // memory port
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   sps_pkg::entry_type mem_rd_data;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   sps_pkg::entry_type mem_wr_data;

   sps_entry_ram #(
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   always_comb begin
      logic          issue;
      logic          place;
      logic [CW-1:0] next_count;

      state_in     = state_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      pend_in      = 1'b0;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      cmd_in       = cmd_ff;
      pid_in       = pid_ff;
      stat_in      = stat_ff;
      d_idx_in     = d_idx_ff;
      hold_in      = hold_ff;
      word_in      = word_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_count_in = rsp_count_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = rd_ptr_ff[AW-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_addr  = d_idx_ff;
      mem_wr_data  = hold_ff;
      issue        = 1'b0;
      place        = 1'b0;
      next_count   = count_ff;

      unique case (state_ff)
         sps_pkg::ST_IDLE: begin
            rd_ptr_in = '0;
            hit_in    = 1'b0;
            if (start) begin
               cmd_in  = sps_pkg::cmd_type'(req_cmd);
               pid_in  = req_pid;
               stat_in = req_status_in;
               word_in = sps_pkg::WORD_DNE;
               if ((sps_pkg::cmd_type'(req_cmd) == sps_pkg::CMD_INSERT) &&
                   (count_ff == CAP_COUNT)) begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = sps_pkg::RC_FULL;
                  rsp_word_in  = sps_pkg::WORD_DNE;
                  rsp_count_in = (sps_pkg::COUNT_W)'(count_ff);
               end else if (count_ff == '0) begin
                  state_in = sps_pkg::ST_FINISH;
               end else begin
                  state_in = sps_pkg::ST_SCAN;
               end
            end
         end

         sps_pkg::ST_SCAN: begin
            issue = (rd_ptr_ff < count_ff);
            if (issue) begin
               mem_rd_en = 1'b1;
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end else begin
               state_in = sps_pkg::ST_FINISH;
            end
            pend_in  = issue;
            d_idx_in = rd_ptr_ff[AW-1:0];

            if (pend_ff) begin
               unique case (cmd_ff)
                  sps_pkg::CMD_INSERT: begin
                     place = !hit_ff && ((d_idx_ff == '0) ? (mem_rd_data.pid > pid_ff)
                                                          : (mem_rd_data.pid >= pid_ff));
                     if (place) begin
                        mem_wr_en          = 1'b1;
                        mem_wr_data.pid    = pid_ff;
                        mem_wr_data.status = sps_pkg::WORD_WAITING;
                        hold_in            = mem_rd_data;
                        hit_in             = 1'b1;
                     end else if (hit_ff) begin
                        mem_wr_en = 1'b1;
                        hold_in   = mem_rd_data;
                     end
                  end
                  sps_pkg::CMD_DELETE: begin
                     if (hit_ff) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = d_idx_ff - AW'(1);
                        mem_wr_data = mem_rd_data;
                     end else if (mem_rd_data.pid == pid_ff) begin
                        hit_in  = 1'b1;
                        word_in = mem_rd_data.status;
                     end
                  end
                  sps_pkg::CMD_UPDATE: begin
                     if (!hit_ff && (mem_rd_data.pid == pid_ff)) begin
                        hit_in             = 1'b1;
                        word_in            = stat_ff;
                        mem_wr_en          = 1'b1;
                        mem_wr_data.pid    = mem_rd_data.pid;
                        mem_wr_data.status = stat_ff;
                     end
                  end
                  sps_pkg::CMD_LOOKUP: begin
                     if (!hit_ff && (mem_rd_data.pid == pid_ff)) begin
                        hit_in  = 1'b1;
                        word_in = mem_rd_data.status;
                     end
                  end
               endcase
            end
         end

         sps_pkg::ST_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = sps_pkg::ST_IDLE;
            rsp_code_in  = sps_pkg::RC_OK;
            rsp_word_in  = word_ff;
            unique case (cmd_ff)
               sps_pkg::CMD_INSERT: begin
                  // append the displaced entry, or the new one if it sorts last
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = count_ff[AW-1:0];
                  if (!hit_ff) begin
                     mem_wr_data.pid    = pid_ff;
                     mem_wr_data.status = sps_pkg::WORD_WAITING;
                  end
                  next_count  = count_ff + CW'(1);
                  rsp_word_in = sps_pkg::WORD_WAITING;
               end
               sps_pkg::CMD_DELETE: begin
                  if (hit_ff) begin
                     next_count = count_ff - CW'(1);
                  end else begin
                     rsp_code_in = sps_pkg::RC_MISS;
                     rsp_word_in = sps_pkg::WORD_DNE;
                  end
               end
               sps_pkg::CMD_UPDATE,
               sps_pkg::CMD_LOOKUP: begin
                  if (!hit_ff) begin
                     rsp_code_in = sps_pkg::RC_MISS;
                     rsp_word_in = sps_pkg::WORD_DNE;
                  end
               end
            endcase
            count_in     = next_count;
            rsp_count_in = (sps_pkg::COUNT_W)'(next_count);
         end

         default: begin
            state_in = sps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sps_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      pid_ff       <= pid_in;
      stat_ff      <= stat_in;
      d_idx_ff     <= d_idx_in;
      hold_ff      <= hold_in;
      word_ff      <= word_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy            = (state_ff != sps_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_status_out  = rsp_word_ff;
   assign rsp_entry_count = rsp_count_ff;

   // assertions
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_COUNT,
                   "count over capacity")
   `ASSERT_NEXT(a_full_reject, clock, reset,
                start && !busy && (req_cmd == sps_pkg::CMD_INSERT) && (count_ff == CAP_COUNT),
                rsp_valid && (rsp_result_code == sps_pkg::RC_FULL),
                "full insert not rejected")
   `ASSERT_NEXT(a_finish_resp, clock, reset, state_ff == sps_pkg::ST_FINISH,
                rsp_valid && (state_ff == sps_pkg::ST_IDLE), "finish without response")
   `ASSERT_IMPLIES(a_pend_in_scan, clock, reset, pend_ff, state_ff == sps_pkg::ST_SCAN,
                   "read data outside scan")

endmodule

// ===== sim/sorted_pid_status_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_pid_status_table_test
// self-checking bench for the sorted pid status table
// ----------------------------------------------------------------------------
// A short directed sequence covers the empty table, both pid extremes,
// duplicates equal to the head entry, first-match update, delete and lookup,
// and misses. Random traffic then cycles through fill, mixed and drain
// phases, so the table runs full and empty many times, with inserts into a
// full table. Every accepted item is run through a local copy of the table
// and the expected result is queued. Each strobed result is compared field
// by field with the oldest queued one. The sender idles in random bursts,
// except in the last part of the run.
// ----------------------------------------------------------------------------
module sorted_pid_status_table_test;
   import sps_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 1580;
   localparam int QUIET_TAIL   = 150;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;
   localparam logic [PID_W-1:0] PID_MAX = {PID_W{1'b1}};

   typedef struct packed {
      cmd_type             cmd;
      logic [PID_W-1:0]    pid;
      logic [STATUS_W-1:0] status;
   } command_item;

   typedef struct packed {
      code_type            code;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } result_item;

   typedef enum int {
      PH_FILL,
      PH_MIXED,
      PH_DRAIN
   } gen_phase;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_cmd = CMD_LOOKUP;
   logic [PID_W-1:0] req_pid = '0;
   logic [STATUS_W-1:0] req_status_in = '0;
   logic rsp_valid;
   logic [CODE_W-1:0] rsp_result_code;
   logic [STATUS_W-1:0] rsp_status_out;
   logic [COUNT_W-1:0] rsp_entry_count;

   command_item pending_items[$];
   result_item expected_results[$];

   // local copy of the table
   logic [PID_W-1:0] table_ids[TABLE_DEPTH];
   logic [STATUS_W-1:0] table_status[TABLE_DEPTH];
   int table_used = 0;
   int table_peak = 0;

   // generator view of stored ids, used to aim commands at hits
   logic [PID_W-1:0] stored_ids[$];

   int error_count = 0;
   int gap_left = 0;
   int cmd_count[4] = '{0, 0, 0, 0};
   int code_count[3] = '{0, 0, 0};

   sorted_pid_status_table #(
      .CAPACITY(TABLE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_pid(req_pid),
      .req_status_in(req_status_in),
      .rsp_valid(rsp_valid),
      .rsp_result_code(rsp_result_code),
      .rsp_status_out(rsp_status_out),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic result_item apply_command(command_item c);
      result_item r;
      int pos;
      int hit;
      r.code = RC_OK;
      r.status = WORD_DNE;
      if (c.cmd == CMD_INSERT) begin
         if (table_used >= TABLE_DEPTH) begin
            r.code = RC_FULL;
         end else begin
            if (table_used == 0 || table_ids[0] > c.pid) begin
               pos = 0;
            end else begin
               pos = 1;
               while (pos < table_used && table_ids[pos] < c.pid) pos++;
            end
            for (int i = table_used; i > pos; i--) begin
               table_ids[i] = table_ids[i-1];
               table_status[i] = table_status[i-1];
            end
            table_ids[pos] = c.pid;
            table_status[pos] = WORD_WAITING;
            table_used++;
            if (table_used > table_peak) table_peak = table_used;
            r.status = WORD_WAITING;
         end
      end else begin
         hit = -1;
         for (int i = 0; i < table_used; i++) begin
            if (hit < 0 && table_ids[i] == c.pid) hit = i;
         end
         if (hit < 0) begin
            r.code = RC_MISS;
         end else if (c.cmd == CMD_DELETE) begin
            r.status = table_status[hit];
            for (int i = hit; i + 1 < table_used; i++) begin
               table_ids[i] = table_ids[i+1];
               table_status[i] = table_status[i+1];
            end
            table_used--;
         end else if (c.cmd == CMD_UPDATE) begin
            table_status[hit] = c.status;
            r.status = c.status;
         end else begin
            r.status = table_status[hit];
         end
      end
      r.count = COUNT_W'(table_used);
      return r;
   endfunction

   // keeps the generator view of stored ids in step with what is queued
   task automatic queue_item(cmd_type cmd, logic [PID_W-1:0] pid, logic [STATUS_W-1:0] status);
      command_item c;
      int hit;
      c.cmd = cmd;
      c.pid = pid;
      c.status = status;
      pending_items.push_back(c);
      hit = -1;
      if (cmd == CMD_INSERT) begin
         if (stored_ids.size() < TABLE_DEPTH) stored_ids.push_back(pid);
      end else if (cmd == CMD_DELETE) begin
         foreach (stored_ids[i]) begin
            if (hit < 0 && stored_ids[i] == pid) hit = i;
         end
         if (hit >= 0) stored_ids.delete(hit);
      end
   endtask

   function automatic logic [PID_W-1:0] pick_pid(int hit_bias);
      int r;
      r = $urandom_range(0, 99);
      if (stored_ids.size() > 0 && r < hit_bias)
         return stored_ids[$urandom_range(0, stored_ids.size() - 1)];
      r = $urandom_range(0, 99);
      if (r < 55) return PID_W'($urandom_range(0, 40));
      if (r < 75) return PID_MAX - PID_W'($urandom_range(0, 40));
      return PID_W'($urandom);
   endfunction

   function automatic logic [STATUS_W-1:0] pick_status();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic cmd_type pick_cmd(gen_phase ph);
      int r;
      r = $urandom_range(0, 99);
      case (ph)
         PH_FILL: begin
            if (r < 85) return CMD_INSERT;
            if (r < 90) return CMD_DELETE;
            if (r < 95) return CMD_UPDATE;
            return CMD_LOOKUP;
         end
         PH_DRAIN: begin
            if (r < 65) return CMD_DELETE;
            if (r < 78) return CMD_LOOKUP;
            if (r < 91) return CMD_UPDATE;
            return CMD_INSERT;
         end
         default: begin
            case (r % 4)
               0: return CMD_INSERT;
               1: return CMD_DELETE;
               2: return CMD_UPDATE;
               default: return CMD_LOOKUP;
            endcase
         end
      endcase
   endfunction

   task automatic build_random();
      gen_phase ph;
      int phase_left;
      cmd_type cmd;
      ph = PH_FILL;
      phase_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         cmd = pick_cmd(ph);
         queue_item(cmd, pick_pid(ph == PH_DRAIN ? 90 : 50), pick_status());
         case (ph)
            PH_FILL: begin
               if (stored_ids.size() == TABLE_DEPTH) begin
                  if (phase_left == 0) phase_left = $urandom_range(2, 6);
                  else phase_left--;
                  if (phase_left == 1) begin
                     ph = PH_MIXED;
                     phase_left = $urandom_range(60, 150);
                  end
               end
            end
            PH_MIXED: begin
               phase_left--;
               if (phase_left <= 0) ph = PH_DRAIN;
            end
            default: begin
               if (stored_ids.size() == 0) begin
                  ph = PH_FILL;
                  phase_left = 0;
               end
            end
         endcase
      end
   endtask

   // driver
   always @(posedge clock) begin
      command_item c;
      logic accepted;
      if (reset) begin
         start <= 1'b0;
      end else begin
         accepted = start && !busy;
         if (accepted) begin
            c.cmd = cmd_type'(req_cmd);
            c.pid = req_pid;
            c.status = req_status_in;
            expected_results.push_back(apply_command(c));
            cmd_count[req_cmd]++;
            if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 10);
         end
         if (!start || accepted) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_items.size() > 0) begin
               c = pending_items.pop_front();
               req_cmd <= c.cmd;
               req_pid <= c.pid;
               req_status_in <= c.status;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      result_item e;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding");
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (e.code < 3) code_count[e.code]++;
            if (rsp_result_code !== e.code) begin
               $error("result_code expected %0d actual %0d", e.code, rsp_result_code);
               error_count++;
            end
            if (rsp_status_out !== e.status) begin
               $error("status_out expected %h actual %h", e.status, rsp_status_out);
               error_count++;
            end
            if (rsp_entry_count !== e.count) begin
               $error("entry_count expected %0d actual %0d", e.count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      // empty table misses
      queue_item(CMD_LOOKUP, '0, '0);
      queue_item(CMD_DELETE, PID_W'(5), '1);
      queue_item(CMD_UPDATE, PID_W'(5), '1);
      // head placement and duplicates of the head entry
      queue_item(CMD_INSERT, PID_W'(100), '1);
      queue_item(CMD_INSERT, PID_W'(100), '0);
      queue_item(CMD_INSERT, PID_W'(50), '0);
      queue_item(CMD_INSERT, '0, '0);
      queue_item(CMD_INSERT, PID_MAX, '1);
      queue_item(CMD_INSERT, PID_W'(100), '0);
      // first match only
      queue_item(CMD_UPDATE, PID_W'(100), '1);
      queue_item(CMD_LOOKUP, PID_W'(100), '0);
      queue_item(CMD_UPDATE, PID_W'(100), '0);
      queue_item(CMD_DELETE, PID_W'(100), '1);
      queue_item(CMD_LOOKUP, PID_W'(100), '1);
      queue_item(CMD_LOOKUP, PID_MAX, '0);
      queue_item(CMD_UPDATE, PID_MAX, {32{2'b01}});
      queue_item(CMD_UPDATE, '0, {32{2'b10}});
      queue_item(CMD_DELETE, '0, '0);
      queue_item(CMD_DELETE, PID_MAX, '0);
      queue_item(CMD_LOOKUP, PID_W'(7), '1);
      queue_item(CMD_INSERT, PID_W'(75), '1);
      queue_item(CMD_DELETE, PID_W'(50), '0);
      build_random();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_items.size() > 0 || start || expected_results.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() > 0) begin
         $error("%0d results never arrived", expected_results.size());
         error_count++;
      end

      $display("ran %0d inserts, %0d deletes, %0d updates, %0d lookups",
               cmd_count[CMD_INSERT], cmd_count[CMD_DELETE],
               cmd_count[CMD_UPDATE], cmd_count[CMD_LOOKUP]);
      $display("outcomes: %0d done, %0d not found, %0d table full; peak occupancy %0d",
               code_count[RC_OK], code_count[RC_MISS], code_count[RC_FULL], table_peak);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout waiting for results");
      $display("Verification failed");
      $finish;
   end

endmodule
